// ===== src/btndb_pkg.sv =====
// Shared types, codes and reset values for the button debounce block.
`default_nettype none
package btndb_pkg;

  localparam int unsigned BUTTON_COUNT_DEF = 4;
  localparam int unsigned COUNT_W          = 16;
  localparam int unsigned LEVELS_W         = 4;
  localparam int unsigned IDX_W            = 2;
  localparam int unsigned CMD_W            = 2;
  localparam int unsigned CFG_IDX_W        = 2;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 16'd5;
  localparam logic [COUNT_W-1:0] HOLD_RESET     = 16'd100;
  localparam logic               PRESSED_RESET  = 1'b0;
  localparam logic               UNPRESSED_INIT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_CLICK = 2'd1,
    CMD_HOLD  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_PRESSED  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] debounce_ticks;
    logic [COUNT_W-1:0] hold_ticks;
    logic               pressed_level;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic clr_click;
    logic clr_hold;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ===== src/btndb_lane.sv =====
// Per-button debounce counter, stable level, hold counter and sticky flags.
`default_nettype none
module btndb_lane (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire btndb_pkg::cfg_t      cfg,
  input  wire btndb_pkg::lane_ctl_t ctl,
  input  wire logic                 level,
  output logic                      pressed_nxt,
  output logic                      click_o,
  output logic                      hold_o
);
  import btndb_pkg::*;

  logic               last_r, last_nxt;
  logic               stable_r, stable_nxt;
  logic [COUNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [COUNT_W-1:0] hcnt_r, hcnt_nxt;
  logic               click_r, click_nxt;
  logic               hold_r, hold_nxt;

  logic               take;
  logic [COUNT_W-1:0] hcnt_base;
  logic [COUNT_W-1:0] dcnt_tick;
  logic               stable_tick;

  always_comb begin
    if (level != last_r) begin
      dcnt_tick = cfg.debounce_ticks;
    end else if (dcnt_r != '0) begin
      dcnt_tick = dcnt_r - 1'b1;
    end else begin
      dcnt_tick = dcnt_r;
    end
    take        = (dcnt_tick == '0) && (level != stable_r);
    stable_tick = take ? level : stable_r;
    hcnt_base   = take ? '0 : hcnt_r;

    last_nxt   = last_r;
    stable_nxt = stable_r;
    dcnt_nxt   = dcnt_r;
    hcnt_nxt   = hcnt_r;
    click_nxt  = click_r;
    hold_nxt   = hold_r;

    if (ctl.tick) begin
      last_nxt   = level;
      stable_nxt = stable_tick;
      dcnt_nxt   = dcnt_tick;
      if (dcnt_tick == '0) begin
        hcnt_nxt = hcnt_base;
        if ((stable_tick == cfg.pressed_level) && (hcnt_base != '1)) begin
          hcnt_nxt = hcnt_base + 1'b1;
        end
      end
      if (take && (level != cfg.pressed_level)) begin
        if (hcnt_r >= cfg.hold_ticks) begin
          hold_nxt = 1'b1;
        end else begin
          click_nxt = 1'b1;
        end
      end
    end
    if (ctl.clr_click) begin
      click_nxt = 1'b0;
    end
    if (ctl.clr_hold) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= UNPRESSED_INIT;
      stable_r <= UNPRESSED_INIT;
      dcnt_r   <= '0;
      hcnt_r   <= '0;
      click_r  <= 1'b0;
      hold_r   <= 1'b0;
    end else begin
      last_r   <= last_nxt;
      stable_r <= stable_nxt;
      dcnt_r   <= dcnt_nxt;
      hcnt_r   <= hcnt_nxt;
      click_r  <= click_nxt;
      hold_r   <= hold_nxt;
    end
  end

  assign pressed_nxt = (stable_nxt == cfg.pressed_level);
  assign click_o     = click_r;
  assign hold_o      = hold_r;

endmodule
`default_nettype wire

// ===== src/button_debounce_click_hold.sv =====
// Top level of the button bank debouncer with click and hold detection.
// Path: an accepted request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input stalls only while the result register
// is full and its result is stalled.
// Reset: synchronous active-low reset clears counters, flags and valid bits, sets the
// stored levels to unpressed and loads the configuration reset values.
`default_nettype none
module button_debounce_click_hold #(
  parameter int unsigned BUTTON_COUNT = btndb_pkg::BUTTON_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [btndb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [btndb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [btndb_pkg::CMD_W-1:0]      in_command,
  input  wire logic [btndb_pkg::LEVELS_W-1:0]   in_button_levels,
  input  wire logic [btndb_pkg::IDX_W-1:0]      in_button_index,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_flag_was_set,
  output logic [btndb_pkg::LEVELS_W-1:0]        out_stable_pressed
);
  import btndb_pkg::*;

  localparam int unsigned QUERY_SPAN = 1 << IDX_W;

  cfg_t cfg_r;

  logic                s1_v_r;
  logic [CMD_W-1:0]    s1_cmd_r;
  logic [LEVELS_W-1:0] s1_levels_r;
  logic [IDX_W-1:0]    s1_idx_r;

  logic                out_v_r;
  logic                out_flag_r, out_flag_nxt;
  logic [LEVELS_W-1:0] out_pr_r, out_pr_nxt;

  logic adv, fire, in_acc;
  logic is_tick, is_click, is_hold;

  logic [BUTTON_COUNT-1:0] pressed_vec, click_vec, hold_vec;
  logic [QUERY_SPAN-1:0]   click_q, hold_q;

  assign adv      = !out_v_r || !out_stall;
  assign fire     = s1_v_r && adv;
  assign in_stall = s1_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    is_tick  = 1'b0;
    is_click = 1'b0;
    is_hold  = 1'b0;
    case (cmd_t'(s1_cmd_r))
      CMD_TICK:  is_tick  = fire;
      CMD_CLICK: is_click = fire;
      CMD_HOLD:  is_hold  = fire;
      default: begin
        is_tick = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks <= DEBOUNCE_RESET;
      cfg_r.hold_ticks     <= HOLD_RESET;
      cfg_r.pressed_level  <= PRESSED_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: cfg_r.debounce_ticks <= cfg_wdata[COUNT_W-1:0];
        REG_HOLD:     cfg_r.hold_ticks     <= cfg_wdata[COUNT_W-1:0];
        REG_PRESSED:  cfg_r.pressed_level  <= cfg_wdata[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_lane
    lane_ctl_t ctl;
    logic      lvl;
    assign ctl.tick = is_tick;
    if (i < QUERY_SPAN) begin : g_q
      assign ctl.clr_click = is_click && (s1_idx_r == IDX_W'(i));
      assign ctl.clr_hold  = is_hold && (s1_idx_r == IDX_W'(i));
    end else begin : g_nq
      assign ctl.clr_click = 1'b0;
      assign ctl.clr_hold  = 1'b0;
    end
    if (i < LEVELS_W) begin : g_lv
      assign lvl = s1_levels_r[i];
    end else begin : g_nlv
      assign lvl = 1'b0;
    end
    btndb_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .cfg         (cfg_r),
      .ctl         (ctl),
      .level       (lvl),
      .pressed_nxt (pressed_vec[i]),
      .click_o     (click_vec[i]),
      .hold_o      (hold_vec[i])
    );
  end

  for (genvar i = 0; i < QUERY_SPAN; i++) begin : g_qry
    if (i < BUTTON_COUNT) begin : g_on
      assign click_q[i] = click_vec[i];
      assign hold_q[i]  = hold_vec[i];
    end else begin : g_off
      assign click_q[i] = 1'b0;
      assign hold_q[i]  = 1'b0;
    end
  end

  for (genvar i = 0; i < LEVELS_W; i++) begin : g_pr
    if (i < BUTTON_COUNT) begin : g_on
      assign out_pr_nxt[i] = pressed_vec[i];
    end else begin : g_off
      assign out_pr_nxt[i] = 1'b0;
    end
  end

  always_comb begin
    out_flag_nxt = 1'b0;
    if (is_click) begin
      out_flag_nxt = click_q[s1_idx_r];
    end else if (is_hold) begin
      out_flag_nxt = hold_q[s1_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (fire) begin
        s1_v_r <= 1'b0;
      end
      if (fire) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r    <= in_command;
      s1_levels_r <= in_button_levels;
      s1_idx_r    <= in_button_index;
    end
    if (fire) begin
      out_flag_r <= out_flag_nxt;
      out_pr_r   <= out_pr_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_flag_was_set   = out_flag_r;
  assign out_stable_pressed = out_pr_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_v_r)
    else $error("input stalled with empty input register");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("processed request produced no result");

  a_held_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(s1_cmd_r) && $stable(s1_idx_r)))
    else $error("stalled request lost from input register");

  a_tick_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick |=> !out_flag_was_set)
    else $error("tick request reported a flag");

endmodule
`default_nettype wire

// ===== dv/tb_button_debounce_click_hold.sv =====
// Self-checking testbench for the button bank debouncer with click and hold detection.
module tb_button_debounce_click_hold;
  import btndb_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_SPARE      = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 2'd3;
  localparam int                   NBUTTONS       = BUTTON_COUNT_DEF;
  localparam int                   WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [LEVELS_W-1:0] levels;
    logic [IDX_W-1:0]    index;
  } btn_request_t;

  typedef struct packed {
    logic                flag;
    logic [LEVELS_W-1:0] pressed;
  } btn_report_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      in_command = '0;
  logic [LEVELS_W-1:0]   in_button_levels = '0;
  logic [IDX_W-1:0]      in_button_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_flag_was_set;
  logic [LEVELS_W-1:0]   out_stable_pressed;

  button_debounce_click_hold uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_button_levels   (in_button_levels),
    .in_button_index    (in_button_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_flag_was_set   (out_flag_was_set),
    .out_stable_pressed (out_stable_pressed)
  );

  // Predicted copy of the configuration and the per-button state.
  logic [COUNT_W-1:0] cfg_settle;
  logic [COUNT_W-1:0] cfg_hold;
  logic               cfg_press;
  logic               seen_lvl    [NBUTTONS];
  logic               settled_lvl [NBUTTONS];
  logic [COUNT_W-1:0] settle_cnt  [NBUTTONS];
  logic [COUNT_W-1:0] press_cnt   [NBUTTONS];
  logic               click_flag  [NBUTTONS];
  logic               long_flag   [NBUTTONS];

  btn_request_t request_q[$];
  btn_report_t  report_q[$];
  btn_request_t live_req;
  logic [LEVELS_W-1:0] intent;

  int pushed_count;
  int accepted_count;
  int tick_count;
  int query_count;
  int spare_count;
  int clicks_seen;
  int holds_seen;
  int settings_used;
  int mismatch_count;
  int in_gap_pct;
  int out_stall_pct;
  int gap_left;
  int stall_left;
  int quiet_cycles;

  function automatic btn_report_t debounce_predict(btn_request_t r);
    btn_report_t rep;
    logic lv;
    rep.flag = 1'b0;
    if (r.command == CMD_TICK) begin
      tick_count++;
      for (int b = 0; b < NBUTTONS; b++) begin
        lv = r.levels[b];
        if (lv != seen_lvl[b]) settle_cnt[b] = cfg_settle;
        else if (settle_cnt[b] != '0) settle_cnt[b] = settle_cnt[b] - 1'b1;
        if (settle_cnt[b] == '0) begin
          if (lv != settled_lvl[b]) begin
            settled_lvl[b] = lv;
            if (lv != cfg_press) begin
              if (press_cnt[b] >= cfg_hold) long_flag[b] = 1'b1;
              else click_flag[b] = 1'b1;
            end
            press_cnt[b] = '0;
          end
          if (settled_lvl[b] == cfg_press && press_cnt[b] != '1)
            press_cnt[b] = press_cnt[b] + 1'b1;
        end
        seen_lvl[b] = lv;
      end
    end else if (r.command == CMD_CLICK) begin
      query_count++;
      rep.flag = click_flag[r.index];
      click_flag[r.index] = 1'b0;
      clicks_seen += rep.flag;
    end else if (r.command == CMD_HOLD) begin
      query_count++;
      rep.flag = long_flag[r.index];
      long_flag[r.index] = 1'b0;
      holds_seen += rep.flag;
    end else begin
      spare_count++;
    end
    for (int b = 0; b < NBUTTONS; b++) rep.pressed[b] = (settled_lvl[b] == cfg_press);
    return rep;
  endfunction

  function automatic void push_request(logic [CMD_W-1:0] cmd, logic [LEVELS_W-1:0] levels,
                                       logic [IDX_W-1:0] idx);
    btn_request_t r;
    r.command = cmd;
    r.levels  = levels;
    r.index   = idx;
    request_q.push_back(r);
    pushed_count++;
  endfunction

  // Mostly press and release sequences with bounce, mixed with flag queries and unused commands.
  function automatic void push_traffic(int n, int toggle_pct, int bounce_pct);
    int r;
    logic [LEVELS_W-1:0] noise;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 14) begin
        push_request(CMD_CLICK, LEVELS_W'($urandom), IDX_W'($urandom));
      end else if (r < 28) begin
        push_request(CMD_HOLD, LEVELS_W'($urandom), IDX_W'($urandom));
      end else if (r < 31) begin
        push_request(CMD_SPARE, LEVELS_W'($urandom), IDX_W'($urandom));
      end else begin
        for (int b = 0; b < NBUTTONS; b++) begin
          if ($urandom_range(0, 99) < toggle_pct) intent[b] = ~intent[b];
          noise[b] = ($urandom_range(0, 99) < bounce_pct);
        end
        push_request(CMD_TICK, intent ^ noise, IDX_W'($urandom));
      end
    end
  endfunction

  task automatic drain();
    while (pushed_count != accepted_count || report_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEBOUNCE: cfg_settle = val;
      REG_HOLD:     cfg_hold   = val;
      REG_PRESSED:  cfg_press  = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [COUNT_W-1:0] settle, logic [COUNT_W-1:0] hold,
                            logic press);
    write_reg(REG_DEBOUNCE, settle);
    write_reg(REG_HOLD, hold);
    write_reg(REG_PRESSED, {{(CFG_DATA_W-1){1'b0}}, press});
    settings_used++;
    intent = {LEVELS_W{~cfg_press}};
  endtask

  // Each half ends with a full drain, so the sender waits for every result.
  task automatic run_traffic(int n, int toggle_pct, int bounce_pct, int max_pct);
    in_gap_pct    = $urandom_range(0, max_pct);
    out_stall_pct = $urandom_range(0, max_pct);
    push_traffic(n / 2, toggle_pct, bounce_pct);
    drain();
    in_gap_pct    = $urandom_range(0, max_pct);
    out_stall_pct = $urandom_range(0, max_pct);
    push_traffic(n - n / 2, toggle_pct, bounce_pct);
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        report_q.push_back(debounce_predict(live_req));
        accepted_count++;
        if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct)
          gap_left = $urandom_range(1, 3);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          live_req = request_q.pop_front();
          in_command       <= live_req.command;
          in_button_levels <= live_req.levels;
          in_button_index  <= live_req.index;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    btn_report_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("result with no request outstanding: flag_was_set %0d stable_pressed %h",
                 out_flag_was_set, out_stable_pressed);
          mismatch_count++;
        end else begin
          want = report_q.pop_front();
          if (out_flag_was_set !== want.flag) begin
            $error("flag_was_set mismatch: expected %0d, actual %0d",
                   want.flag, out_flag_was_set);
            mismatch_count++;
          end
          if (out_stable_pressed !== want.pressed) begin
            $error("stable_pressed mismatch: expected %h, actual %h",
                   want.pressed, out_stable_pressed);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("button_debounce_click_hold test failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_settle = DEBOUNCE_RESET;
    cfg_hold   = HOLD_RESET;
    cfg_press  = PRESSED_RESET;
    for (int b = 0; b < NBUTTONS; b++) begin
      seen_lvl[b]    = UNPRESSED_INIT;
      settled_lvl[b] = UNPRESSED_INIT;
      settle_cnt[b]  = '0;
      press_cnt[b]   = '0;
      click_flag[b]  = 1'b0;
      long_flag[b]   = 1'b0;
    end
    intent        = {LEVELS_W{UNPRESSED_INIT}};
    in_gap_pct    = 20;
    out_stall_pct = 20;
    settings_used = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration, then zero debounce with a short hold threshold.
    push_request(CMD_TICK, 4'hF, 2'd0);
    push_request(CMD_CLICK, 4'h0, 2'd0);
    push_request(CMD_HOLD, 4'hF, 2'd3);
    push_request(CMD_SPARE, 4'h5, 2'd2);
    drain();
    set_config(16'd0, 16'd2, 1'b0);
    push_request(CMD_TICK, 4'hE, 2'd1);
    push_request(CMD_TICK, 4'hE, 2'd2);
    push_request(CMD_TICK, 4'hE, 2'd3);
    push_request(CMD_TICK, 4'hF, 2'd0);
    push_request(CMD_TICK, 4'hD, 2'd0);
    push_request(CMD_TICK, 4'hF, 2'd0);
    push_request(CMD_HOLD, 4'hA, 2'd0);
    push_request(CMD_HOLD, 4'h5, 2'd0);
    push_request(CMD_CLICK, 4'h0, 2'd1);
    push_request(CMD_CLICK, 4'hF, 2'd0);
    push_request(CMD_TICK, 4'h0, 2'd0);
    push_request(CMD_TICK, 4'hF, 2'd0);
    push_request(CMD_CLICK, 4'h3, 2'd2);
    push_request(CMD_CLICK, 4'hC, 2'd3);
    push_request(CMD_SPARE, 4'h0, 2'd3);
    push_request(CMD_SPARE, 4'hF, 2'd1);
    drain();

    set_config(16'd2, 16'd8, 1'b0);
    run_traffic(300, 7, 6, 40);

    set_config(16'd0, 16'd0, 1'b1);
    run_traffic(250, 8, 4, 40);

    set_config(COUNT_W'($urandom_range(0, 4)), COUNT_W'($urandom_range(1, 20)),
               1'($urandom_range(0, 1)));
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_PRESSED, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE, 16'hFFFF);
    run_traffic(300, 6, 8, 50);

    set_config(16'hFFFF, 16'hFFFF, 1'b0);
    run_traffic(120, 10, 10, 30);

    set_config(16'd3, 16'd12, 1'b1);
    run_traffic(150, 6, 5, 40);
    write_reg(REG_PRESSED, {{(CFG_DATA_W-1){1'b0}}, ~cfg_press});
    settings_used++;
    run_traffic(150, 6, 5, 40);

    set_config(16'd1, 16'd5, 1'b0);
    run_traffic(300, 8, 5, 0);

    drain();
    repeat (8) @(posedge clk);
    if (report_q.size() != 0) begin
      $error("%0d expected results never arrived", report_q.size());
      mismatch_count++;
    end
    $display("Covered %0d requests: %0d ticks, %0d flag queries, %0d unused commands.",
             accepted_count, tick_count, query_count, spare_count);
    $display("Saw %0d clicks and %0d holds over %0d settings.",
             clicks_seen, holds_seen, settings_used);
    if (mismatch_count == 0) begin
      $display("button_debounce_click_hold test passed");
    end else begin
      $display("button_debounce_click_hold test failed");
    end
    $finish;
  end

endmodule
